// ----- sv/u8rtf_pkg.sv -----
// Shared types and constants of the UTF-8 to RTF unicode escape converter.
package u8rtf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned MagW    = 17;
  localparam int unsigned NDigits = 5;
  localparam int unsigned IdxW    = $clog2(NDigits);
  localparam int unsigned DigitW  = 4;

  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChU         = 8'h75;
  localparam logic [ByteW-1:0] ChMinus     = 8'h2D;
  localparam logic [ByteW-1:0] ChZero      = 8'h30;
  localparam logic [ByteW-1:0] ChQmark     = 8'h3F;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NDigits - 1);

  typedef enum logic [2:0] {
    SEL_IN,
    SEL_BSL,
    SEL_U,
    SEL_MINUS,
    SEL_DIGIT,
    SEL_QMARK
  } byte_sel_e;

  typedef struct packed {
    logic            lead;
    logic            cont;
    logic            mag_load;
    logic            digit_step;
    logic            out_load;
    byte_sel_e       out_sel;
    logic            out_last;
    logic [IdxW-1:0] dig_idx;
  } cmd_t;

  typedef struct packed {
    logic pending_nz;
    logic pending_one;
    logic in_ascii;
    logic in_lead;
    logic neg;
    logic digit_zero;
  } sts_t;

  // Power of ten for a digit position, most significant first.
  function automatic logic [MagW-1:0] dec_weight(logic [IdxW-1:0] idx);
    logic [MagW-1:0] w;
    case (idx)
      3'd0:    w = MagW'(10000);
      3'd1:    w = MagW'(1000);
      3'd2:    w = MagW'(100);
      3'd3:    w = MagW'(10);
      default: w = MagW'(1);
    endcase
    return w;
  endfunction

endpackage

// ----- sv/utf8_to_rtf_unicode_escape.sv -----
// Top level: UTF-8 byte stream to RTF text with \uN? escapes.
// A byte below 0x80 outside a sequence is accepted and loaded into the output
// register, so plain ASCII streams at one byte per cycle while the output is not
// stalled. Lead and continuation bytes are accepted one per cycle under the same
// condition and produce nothing until the sequence completes. The byte that
// completes it starts an escape that emits backslash, 'u', an optional minus sign,
// the decimal digits and '?': the digit unit walks the five decimal positions one
// per cycle while the output is not stalled. No input is accepted until '?' is sent.
module utf8_to_rtf_unicode_escape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  u8rtf_pkg::cmd_t cmd;
  u8rtf_pkg::sts_t sts;

  u8rtf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  u8rtf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_byte_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule

// ----- sv/u8rtf_dp.sv -----
// Datapath: sequence accumulator, decimal digit extraction and output data register.
module u8rtf_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            in_byte_i,
  input  u8rtf_pkg::cmd_t       cmd_i,
  output u8rtf_pkg::sts_t       sts_o,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);

  logic [2:0]                       pending_q, pending_d;
  logic [u8rtf_pkg::CodeW-1:0]      acc_q, acc_d;
  logic [u8rtf_pkg::MagW-1:0]       mag_q, mag_d;
  logic [7:0]                       out_byte_q, out_byte_d;
  logic                             out_last_q;
  logic [2:0]                       lead_pend;
  logic [7:0]                       lead_mask;
  logic [u8rtf_pkg::MagW-1:0]       weight;
  logic [u8rtf_pkg::DigitW-1:0]     digit;
  logic [u8rtf_pkg::MagW+3:0]       sub;

  always_comb begin
    case (in_byte_i) inside
      8'b110?_????: begin lead_pend = 3'd1; lead_mask = 8'h1F; end
      8'b1110_????: begin lead_pend = 3'd2; lead_mask = 8'h0F; end
      8'b1111_0???: begin lead_pend = 3'd3; lead_mask = 8'h07; end
      8'b1111_10??: begin lead_pend = 3'd4; lead_mask = 8'h03; end
      8'b1111_110?: begin lead_pend = 3'd5; lead_mask = 8'h01; end
      8'b1111_1110: begin lead_pend = 3'd6; lead_mask = 8'h00; end
      8'b1111_1111: begin lead_pend = 3'd7; lead_mask = 8'h00; end
      default:      begin lead_pend = 3'd0; lead_mask = 8'h00; end
    endcase
  end

  always_comb begin
    weight = u8rtf_pkg::dec_weight(cmd_i.dig_idx);
    digit  = '0;
    for (int k = 1; k <= 9; k++) begin
      if ((u8rtf_pkg::MagW + 4)'(mag_q) >= (u8rtf_pkg::MagW + 4)'(k) * {4'd0, weight}) begin
        digit = u8rtf_pkg::DigitW'(k);
      end
    end
    sub = {4'd0, weight} * {{u8rtf_pkg::MagW{1'b0}}, digit};
  end

  always_comb begin
    pending_d = pending_q;
    acc_d     = acc_q;
    mag_d     = mag_q;
    if (cmd_i.lead) begin
      pending_d = lead_pend;
      acc_d     = {8'd0, in_byte_i & lead_mask};
    end else if (cmd_i.cont) begin
      pending_d = pending_q - 3'd1;
      acc_d     = {acc_q[u8rtf_pkg::CodeW-7:0], in_byte_i[5:0]};
    end
    if (cmd_i.mag_load) begin
      mag_d = acc_q[u8rtf_pkg::CodeW-1]
            ? u8rtf_pkg::MagW'(17'h10000 - {1'b0, acc_q})
            : {1'b0, acc_q};
    end else if (cmd_i.digit_step) begin
      mag_d = mag_q - sub[u8rtf_pkg::MagW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.out_sel)
      u8rtf_pkg::SEL_IN:    out_byte_d = in_byte_i;
      u8rtf_pkg::SEL_BSL:   out_byte_d = u8rtf_pkg::ChBackslash;
      u8rtf_pkg::SEL_U:     out_byte_d = u8rtf_pkg::ChU;
      u8rtf_pkg::SEL_MINUS: out_byte_d = u8rtf_pkg::ChMinus;
      u8rtf_pkg::SEL_DIGIT: out_byte_d = u8rtf_pkg::ChZero + {4'd0, digit};
      default:              out_byte_d = u8rtf_pkg::ChQmark;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      acc_q     <= '0;
    end else begin
      pending_q <= pending_d;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (cmd_i.out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.pending_nz  = (pending_q != 3'd0);
  assign sts_o.pending_one = (pending_q == 3'd1);
  assign sts_o.in_ascii    = !in_byte_i[7];
  assign sts_o.in_lead     = in_byte_i[7] && in_byte_i[6];
  assign sts_o.neg         = acc_q[u8rtf_pkg::CodeW-1];
  assign sts_o.digit_zero  = (digit == '0);

  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

endmodule

// ----- sv/u8rtf_ctrl.sv -----
// Controller: input acceptance, escape sequencing and output valid.
module u8rtf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  u8rtf_pkg::sts_t  sts_i,
  output u8rtf_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BSL,
    ST_U,
    ST_MINUS,
    ST_DIGIT,
    ST_QMARK
  } state_e;

  state_e                     state_q, state_d;
  logic                       valid_q, valid_d;
  logic [u8rtf_pkg::IdxW-1:0] idx_q, idx_d;
  logic                       started_q, started_d;
  logic                       slot_free;
  logic                       accept;
  logic                       emit;

  assign slot_free = !valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept    = s_valid_i && s_ready_o;
  assign emit      = !sts_i.digit_zero || started_q || (idx_q == u8rtf_pkg::LastIdx);

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_sel    = u8rtf_pkg::SEL_IN;
    cmd_o.dig_idx    = idx_q;
    state_d          = state_q;
    idx_d            = idx_q;
    started_d        = started_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.pending_nz) begin
            cmd_o.cont = 1'b1;
            if (sts_i.pending_one) begin
              state_d = ST_BSL;
            end
          end else if (sts_i.in_ascii) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = 1'b1;
          end else if (sts_i.in_lead) begin
            cmd_o.lead = 1'b1;
          end
        end
      end
      ST_BSL: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = u8rtf_pkg::SEL_BSL;
          cmd_o.mag_load = 1'b1;
          state_d        = ST_U;
        end
      end
      ST_U: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = u8rtf_pkg::SEL_U;
          idx_d          = '0;
          started_d      = 1'b0;
          state_d        = sts_i.neg ? ST_MINUS : ST_DIGIT;
        end
      end
      ST_MINUS: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = u8rtf_pkg::SEL_MINUS;
          state_d        = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          cmd_o.digit_step = 1'b1;
          cmd_o.out_load   = emit;
          cmd_o.out_sel    = u8rtf_pkg::SEL_DIGIT;
          started_d        = started_q || emit;
          idx_d            = idx_q + 1'b1;
          if (idx_q == u8rtf_pkg::LastIdx) begin
            state_d = ST_QMARK;
          end
        end
      end
      ST_QMARK: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = u8rtf_pkg::SEL_QMARK;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    valid_d = cmd_o.out_load ? 1'b1 : (m_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= 1'b0;
      idx_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      started_q <= started_d;
    end
  end

  assign m_valid_o = valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_ready_i) |-> !cmd_o.out_load)
    else $error("output overwritten while stalled");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (idx_q <= u8rtf_pkg::LastIdx))
    else $error("digit index out of range");

  a_qmark_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QMARK && slot_free) |=> (state_q == ST_IDLE && valid_q))
    else $error("escape did not close");

  a_digit_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT && slot_free && idx_q == u8rtf_pkg::LastIdx) |-> cmd_o.out_load)
    else $error("units digit not emitted");

endmodule
